/* hdl/upd_pkg.sv */
package upd_pkg;

  localparam logic [7:0] PCT_CHAR  = 8'h25;
  localparam logic [7:0] ASCII_MAX = 8'h7F;

  // escape phase codes
  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HIGH = 2'd2;

  // status / failure codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BADESC = 2'd1;
  localparam logic [1:0] STAT_FORBID = 2'd2;
  localparam logic [1:0] STAT_UTF8   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_ASCII_FORBID = 2'd0;
  localparam logic [1:0] REG_ILLEGAL_EN   = 2'd1;
  localparam logic [1:0] REG_ILLEGAL_CHAR = 2'd2;

  localparam logic [7:0] ILLEGAL_CHAR_RST = 8'd47;

  typedef struct packed {
    logic [1:0] remaining;
    logic [2:0] lead_class;
    logic       stopped;
  } utf8_st_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [3:0] hex_high;
    logic [1:0] fail;
    utf8_st_t   utf;
  } stream_st_t;

  typedef struct packed {
    logic       ascii_forbid;
    logic       illegal_en;
    logic [7:0] illegal_char;
  } cfg_t;

  typedef struct packed {
    logic       present;
    logic [7:0] data;
    logic       emit;
    logic       done;
    logic [1:0] status;
  } result_t;

  localparam stream_st_t STREAM_RST = '{phase: ESC_IDLE, hex_high: 4'd0, fail: STAT_OK,
                                        utf: '{remaining: 2'd0, lead_class: 3'd0,
                                               stopped: 1'b0}};

endpackage

/* hdl/upd_utf8.sv */
module upd_utf8
  import upd_pkg::*;
(
  input  utf8_st_t   cur,
  input  logic [7:0] data,
  output utf8_st_t   nxt,
  output logic       ok
);

  localparam logic [2:0] LC_NONE = 3'd0;
  localparam logic [2:0] LC_E0   = 3'd1;
  localparam logic [2:0] LC_ED   = 3'd2;
  localparam logic [2:0] LC_F0   = 3'd3;
  localparam logic [2:0] LC_F4   = 3'd4;

  logic [7:0] lo;
  logic [7:0] hi;

  // continuation byte window narrowed by the lead byte
  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    case (cur.lead_class)
      LC_E0:   lo = 8'hA0;
      LC_ED:   hi = 8'h9F;
      LC_F0:   lo = 8'h90;
      LC_F4:   hi = 8'h8F;
      default: ;
    endcase
  end

  always_comb begin
    nxt = cur;
    ok  = 1'b1;
    if (cur.stopped) begin
      ok = 1'b1;
    end else if (cur.remaining == 2'd0) begin
      nxt.lead_class = LC_NONE;
      if (data == 8'h00) begin
        nxt.stopped = 1'b1;
      end else if (data <= ASCII_MAX) begin
        ok = 1'b1;
      end else if (data < 8'hC2) begin
        ok = 1'b0;
      end else if (data < 8'hE0) begin
        nxt.remaining = 2'd1;
      end else if (data < 8'hF0) begin
        nxt.remaining  = 2'd2;
        nxt.lead_class = (data == 8'hE0) ? LC_E0 : (data == 8'hED) ? LC_ED : LC_NONE;
      end else if (data < 8'hF5) begin
        nxt.remaining  = 2'd3;
        nxt.lead_class = (data == 8'hF0) ? LC_F0 : (data == 8'hF4) ? LC_F4 : LC_NONE;
      end else begin
        ok = 1'b0;
      end
    end else begin
      if (data < lo || data > hi) begin
        ok = 1'b0;
      end else begin
        nxt.lead_class = LC_NONE;
        nxt.remaining  = cur.remaining - 2'd1;
      end
    end
  end

endmodule

/* hdl/upd_step.sv */
module upd_step
  import upd_pkg::*;
(
  input  stream_st_t cur,
  input  cfg_t       cfg,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output stream_st_t nxt,
  output result_t    res
);

  logic       hex_ok;
  logic [3:0] hex_val;
  logic [1:0] fail;
  logic [1:0] phase;
  logic [3:0] hex_high;
  logic       emit;
  logic [7:0] dec;
  logic [7:0] esc_byte;
  utf8_st_t   utf_calc;
  utf8_st_t   utf_nxt;
  logic       utf_ok;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign esc_byte = {cur.hex_high, hex_val};

  // escape decode
  always_comb begin
    fail     = cur.fail;
    phase    = cur.phase;
    hex_high = cur.hex_high;
    emit     = 1'b0;
    dec      = 8'h00;
    if (cur.fail == STAT_OK) begin
      case (cur.phase)
        ESC_IDLE: begin
          if (in_byte == PCT_CHAR) begin
            phase = ESC_PCT;
          end else begin
            dec  = in_byte;
            emit = 1'b1;
          end
        end
        ESC_PCT: begin
          if (!hex_ok) begin
            fail = STAT_BADESC;
          end else begin
            hex_high = hex_val;
            phase    = ESC_HIGH;
          end
        end
        default: begin
          if (!hex_ok) begin
            fail = STAT_BADESC;
          end else begin
            dec = esc_byte;
            if (esc_byte == 8'h00) begin
              fail = STAT_BADESC;
            end else if (cfg.ascii_forbid && esc_byte <= ASCII_MAX) begin
              fail = STAT_FORBID;
            end else if (cfg.illegal_en && esc_byte == cfg.illegal_char) begin
              fail = STAT_FORBID;
            end else begin
              emit = 1'b1;
            end
          end
          phase = ESC_IDLE;
        end
      endcase
    end
  end

  upd_utf8 u_utf8 (
    .cur  (cur.utf),
    .data (dec),
    .nxt  (utf_calc),
    .ok   (utf_ok)
  );

  // UTF-8 check, end-of-string resolution
  always_comb begin
    nxt          = STREAM_RST;
    res          = '0;
    nxt.fail     = fail;
    nxt.phase    = phase;
    nxt.hex_high = hex_high;
    utf_nxt      = cur.utf;
    res.emit     = emit;
    if (emit) begin
      utf_nxt = utf_calc;
      if (!utf_ok) begin
        nxt.fail = STAT_UTF8;
        res.emit = 1'b0;
      end
    end
    nxt.utf = utf_nxt;
    if (nxt.fail != STAT_OK) begin
      nxt.phase = ESC_IDLE;
    end
    if (last_byte) begin
      if (nxt.fail == STAT_OK && nxt.phase != ESC_IDLE) begin
        nxt.fail = STAT_BADESC;
      end
      if (nxt.fail == STAT_OK && !utf_nxt.stopped && utf_nxt.remaining != 2'd0) begin
        nxt.fail = STAT_UTF8;
      end
      res.status = nxt.fail;
    end
    res.done    = last_byte;
    res.data    = res.emit ? dec : 8'h00;
    res.present = res.emit | last_byte;
    if (last_byte) begin
      nxt = STREAM_RST;
    end
  end

endmodule

/* hdl/uri_percent_decoder.sv */
// Streaming percent-escape decoder. One raw URI byte per word on the input
// channel (in_byte, last_byte), with a new word accepted every clock as long
// as the result register is free or being drained in the same cycle, so the
// sustained rate is one byte per cycle; the decode and UTF-8 check of a byte
// is a single pass of combinational logic that lands in the result register.
// A result word is produced for every decoded byte that passes its checks
// and always for the last byte of a string; '%' and the first hex digit of
// an escape produce nothing, nor does anything after a failure.
// The result of the last byte has done_res set and carries status: 0 ok,
// 1 bad or truncated escape, 2 forbidden escape, 3 invalid UTF-8. Bytes
// already delivered before a failure must be dropped by the consumer. The
// configuration registers (0 ascii_escape_forbidden, 1 illegal_enable,
// 2 illegal_char) are written through cfg_we/cfg_index/cfg_data and should
// only change between strings while the block is idle.
module uri_percent_decoder
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // config write port
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // input word
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  // result word
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       done_res,
  output logic [1:0] status
);

  cfg_t       cfg;
  stream_st_t st;
  stream_st_t st_next;
  result_t    res_next;
  logic       acc;

  // Result register frees up in the same cycle it is drained.
  assign in_ready = !res_valid || res_ready;
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ascii_forbid <= 1'b0;
      cfg.illegal_en   <= 1'b0;
      cfg.illegal_char <= ILLEGAL_CHAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ASCII_FORBID: cfg.ascii_forbid <= cfg_data[0];
        REG_ILLEGAL_EN:   cfg.illegal_en   <= cfg_data[0];
        REG_ILLEGAL_CHAR: cfg.illegal_char <= cfg_data;
        default:          ;
      endcase
    end
  end

  upd_step u_step (
    .cur       (st),
    .cfg       (cfg),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .nxt       (st_next),
    .res       (res_next)
  );

  // stream state advances once per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STREAM_RST;
    end else if (acc) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (acc) begin
      res_valid <= res_next.present;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // payload: loaded only when a word is produced
  always_ff @(posedge clk) begin
    if (acc && res_next.present) begin
      out_byte  <= res_next.data;
      out_valid <= res_next.emit;
      done_res  <= res_next.done;
      status    <= res_next.status;
    end
  end

  // Intermediate results always carry a byte and an ok status.
  a_mid_has_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid && !done_res |-> out_valid && status == STAT_OK)
    else $error("intermediate result without byte or with status");

  // A string end leaves the stream state clean for the next string.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    acc && last_byte |=> st.phase == ESC_IDLE && st.fail == STAT_OK &&
                         st.utf.remaining == 2'd0 && !st.utf.stopped)
    else $error("stream state not cleared after last byte");

  // A pending escape never coexists with a recorded failure.
  a_no_pending_on_fail: assert property (@(posedge clk) disable iff (rst)
    st.phase != ESC_IDLE |-> st.fail == STAT_OK)
    else $error("escape pending after failure");

  // Once failed, non-final bytes produce no result.
  a_silent_after_fail: assert property (@(posedge clk) disable iff (rst)
    acc && st.fail != STAT_OK && !last_byte |=> !res_valid)
    else $error("result produced after failure");

endmodule

/* verif/tb_uri_percent_decoder.sv */
import upd_pkg::*;

typedef enum logic [2:0] {LEAD_ANY, LEAD_E0, LEAD_ED, LEAD_F0, LEAD_F4} utf8_lead_t;

typedef struct packed {
  logic [7:0] data;
  logic       emit;
  logic       done;
  logic [1:0] status;
} decoded_word_t;

// Decoder model plus the queue of decoded words still owed by the block.
class decode_scoreboard;
  decoded_word_t decoded_q[$];
  int            errors;
  int            checked;
  int            by_status[4];

  logic       ascii_forbid;
  logic       illegal_en;
  logic [7:0] illegal_char;

  logic [1:0] esc_phase;
  logic [3:0] hex_hi;
  logic [1:0] fail;
  logic [1:0] utf_left;
  utf8_lead_t utf_lead;
  logic       utf_off;

  function new();
    ascii_forbid = 1'b0;
    illegal_en   = 1'b0;
    illegal_char = ILLEGAL_CHAR_RST;
    errors       = 0;
    checked      = 0;
    foreach (by_status[i]) by_status[i] = 0;
    clear_string();
  endfunction

  function void clear_string();
    esc_phase = ESC_IDLE;
    hex_hi    = 4'd0;
    fail      = STAT_OK;
    utf_left  = 2'd0;
    utf_lead  = LEAD_ANY;
    utf_off   = 1'b0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [7:0] val);
    case (idx)
      REG_ASCII_FORBID: ascii_forbid = val[0];
      REG_ILLEGAL_EN:   illegal_en = val[0];
      REG_ILLEGAL_CHAR: illegal_char = val;
      default: ;
    endcase
  endfunction

  function int hex_value(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
    if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
    if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
    return -1;
  endfunction

  // strict UTF-8 tracker; returns 0 when b breaks the sequence
  function bit utf8_step(logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (utf_off) return 1'b1;
    if (utf_left == 2'd0) begin
      utf_lead = LEAD_ANY;
      if (b == 8'h00) begin
        utf_off = 1'b1;
        return 1'b1;
      end
      if (b <= ASCII_MAX) return 1'b1;
      if (b < 8'hC2) return 1'b0;
      if (b < 8'hE0) begin
        utf_left = 2'd1;
        return 1'b1;
      end
      if (b < 8'hF0) begin
        utf_left = 2'd2;
        if (b == 8'hE0) utf_lead = LEAD_E0;
        else if (b == 8'hED) utf_lead = LEAD_ED;
        return 1'b1;
      end
      if (b < 8'hF5) begin
        utf_left = 2'd3;
        if (b == 8'hF0) utf_lead = LEAD_F0;
        else if (b == 8'hF4) utf_lead = LEAD_F4;
        return 1'b1;
      end
      return 1'b0;
    end
    case (utf_lead)
      LEAD_E0: lo = 8'hA0;
      LEAD_ED: hi = 8'h9F;
      LEAD_F0: lo = 8'h90;
      LEAD_F4: hi = 8'h8F;
      default: ;
    endcase
    if (b < lo || b > hi) return 1'b0;
    utf_lead = LEAD_ANY;
    utf_left = utf_left - 2'd1;
    return 1'b1;
  endfunction

  // an input word was accepted: advance the model, queue what it yields
  function void note_word(logic [7:0] b, logic fin);
    logic       emit;
    logic [7:0] c;
    int         h;
    emit = 1'b0;
    c    = 8'h00;
    if (fail == STAT_OK) begin
      case (esc_phase)
        ESC_IDLE: begin
          if (b == PCT_CHAR) esc_phase = ESC_PCT;
          else begin
            c    = b;
            emit = 1'b1;
          end
        end
        ESC_PCT: begin
          h = hex_value(b);
          if (h < 0) fail = STAT_BADESC;
          else begin
            hex_hi    = h[3:0];
            esc_phase = ESC_HIGH;
          end
        end
        default: begin
          h = hex_value(b);
          if (h < 0) fail = STAT_BADESC;
          else begin
            c = {hex_hi, h[3:0]};
            if (c == 8'h00) fail = STAT_BADESC;
            else if (ascii_forbid && c <= ASCII_MAX) fail = STAT_FORBID;
            else if (illegal_en && c == illegal_char) fail = STAT_FORBID;
            else emit = 1'b1;
          end
          esc_phase = ESC_IDLE;
        end
      endcase
      if (emit && !utf8_step(c)) begin
        fail = STAT_UTF8;
        emit = 1'b0;
      end
      if (fail != STAT_OK) esc_phase = ESC_IDLE;
    end
    if (fin) begin
      if (fail == STAT_OK && esc_phase != ESC_IDLE) fail = STAT_BADESC;
      if (fail == STAT_OK && !utf_off && utf_left != 2'd0) fail = STAT_UTF8;
      decoded_q.push_back('{data: emit ? c : 8'h00, emit: emit, done: 1'b1, status: fail});
      by_status[fail]++;
      clear_string();
    end else if (emit) begin
      decoded_q.push_back('{data: c, emit: 1'b1, done: 1'b0, status: STAT_OK});
    end
  endfunction

  task report(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task check_word(logic [7:0] data, logic emit, logic done, logic [1:0] st);
    decoded_word_t want;
    if (decoded_q.size() == 0) begin
      report($sformatf("unexpected word out_byte=%02h out_valid=%0b done=%0b status=%0d",
                       data, emit, done, st));
      return;
    end
    want = decoded_q.pop_front();
    checked++;
    if (emit !== want.emit) report($sformatf("out_valid %0b, want %0b", emit, want.emit));
    if (data !== want.data) report($sformatf("out_byte %02h, want %02h", data, want.data));
    if (done !== want.done) report($sformatf("done_res %0b, want %0b", done, want.done));
    if (st !== want.status) report($sformatf("status %0d, want %0d", st, want.status));
  endtask
endclass

module tb_uri_percent_decoder;
  import upd_pkg::*;

  // no word moving for this long means the block is hung
  localparam int QUIET_LIMIT = 2000;
  // receiver hold-off used to back the block up into its input
  localparam int HOLD_CYCLES = 150;
  // settle margin once no words are owed; covers words that yield nothing
  localparam int SETTLE      = 4;
  // minimum input words per register setting
  localparam int PHASE_WORDS = 140;

  typedef enum int {PH_PLAIN, PH_HOLD, PH_NO_GAPS, PH_MID_DRAIN} phase_mode_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = REG_ASCII_FORBID;
  logic [7:0] cfg_data  = 8'h00;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       last_byte = 1'b0;
  logic       res_ready = 1'b0;
  logic       in_ready;
  logic       res_valid;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       done_res;
  logic [1:0] status;

  decode_scoreboard sb;

  // shared with the receiver: long hold-off request and no-gap stretch
  logic hold_off = 1'b0;
  logic no_gaps  = 1'b0;

  logic [7:0] text_q[$];     // raw bytes of the string being sent
  logic [7:0] cur_illegal = ILLEGAL_CHAR_RST;
  int         n_words     = 0;
  int         n_strings   = 0;
  int         phase_words = 0;
  int         quiet       = 0;

  uri_percent_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .done_res  (done_res),
    .status    (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // gap length: one time in ten from the long range, else from the short one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Monitor: samples both channels at the edge, before this edge's updates land.
  // Results are checked first; a word accepted now cannot have produced one yet.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) sb.check_word(out_byte, out_valid, done_res, status);
      if (in_valid && in_ready) sb.note_word(in_byte, last_byte);
    end
  end

  // Watchdog: counts edges where no word moves on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (res_valid && res_ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("[%0t] watchdog: no traffic for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL uri_percent_decoder");
      $finish;
    end
  end

  // Receiver: random back-pressure, a long hold-off on request, none in no-gap phases
  always begin
    @(posedge clk);
    if (hold_off) begin
      res_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off = 1'b0;
    end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
      res_ready <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Offer one word and hold it until accepted; sometimes idle afterwards.
  task automatic send_word(input logic [7:0] b, input logic fin);
    in_valid  <= 1'b1;
    in_byte   <= b;
    last_byte <= fin;
    do @(posedge clk); while (!in_ready);
    n_words++;
    phase_words++;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic send_string();
    foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
    n_strings++;
  endtask

  // Stop offering and wait until every owed word is back, then let the
  // pipe settle so a register write lands on an idle block.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'd0, n};
    if ($urandom_range(0, 1) == 1) return 8'h41 + {4'd0, n - 4'd10};
    return 8'h61 + {4'd0, n - 4'd10};
  endfunction

  // data byte as raw or as %XX; a literal '%' must always be escaped
  function automatic void add_data(input logic [7:0] b, input bit esc);
    if (esc || b == PCT_CHAR) begin
      text_q.push_back(PCT_CHAR);
      text_q.push_back(hex_char(b[7:4]));
      text_q.push_back(hex_char(b[3:0]));
    end else begin
      text_q.push_back(b);
    end
  endfunction

  // Lead byte of a 2..4 byte sequence; the special leads E0/ED/F0/F4 come up often.
  function automatic logic [7:0] pick_lead(input int len);
    int r;
    r = $urandom_range(0, 3);
    if (len == 2) return 8'($urandom_range(8'hC2, 8'hDF));
    if (len == 3) begin
      if (r == 0) return 8'hE0;
      if (r == 1) return 8'hED;
      return 8'($urandom_range(8'hE0, 8'hEF));
    end
    if (r == 0) return 8'hF0;
    if (r == 1) return 8'hF4;
    return 8'($urandom_range(8'hF0, 8'hF4));
  endfunction

  // Well-formed multibyte character, each byte raw or escaped at random.
  function automatic void add_char();
    int         len;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    len  = $urandom_range(2, 4);
    lead = pick_lead(len);
    lo   = 8'h80;
    hi   = 8'hBF;
    if (lead == 8'hE0) lo = 8'hA0;
    else if (lead == 8'hED) hi = 8'h9F;
    else if (lead == 8'hF0) lo = 8'h90;
    else if (lead == 8'hF4) hi = 8'h8F;
    add_data(lead, 1'($urandom_range(0, 1)));
    add_data(8'($urandom_range(lo, hi)), 1'($urandom_range(0, 1)));
    for (int k = 2; k < len; k++)
      add_data(8'($urandom_range(8'h80, 8'hBF)), 1'($urandom_range(0, 1)));
  endfunction

  // Random string: mostly valid tokens, the rest noise that trips each failure path.
  function automatic void build_string();
    int n_tok;
    int kind;
    text_q.delete();
    n_tok = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
    for (int i = 0; i < n_tok; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) add_data(8'($urandom_range(1, 127)), $urandom_range(0, 3) == 0);
      else if (kind < 62) add_char();
      else if (kind < 67) add_data(cur_illegal, 1'b1);
      else if (kind < 72) add_data(8'h00, 1'b0);          // raw NUL
      else if (kind < 80) add_data(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (kind < 87) begin                           // broken or cut escape
        text_q.push_back(PCT_CHAR);
        if ($urandom_range(0, 2) != 0) begin
          if ($urandom_range(0, 1) == 1)
            text_q.push_back(hex_char(4'($urandom_range(0, 15))));
          text_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      else if (kind < 93)
        add_data(pick_lead($urandom_range(2, 4)), 1'($urandom_range(0, 1)));
      else text_q.push_back(8'($urandom_range(0, 255)));  // anything raw, '%' included
    end
  endfunction

  task automatic run_phase(input logic forbid, input logic ill_en, input logic [7:0] ill_ch,
                           input phase_mode_t mode);
    int sent;
    wait_drained();
    write_reg(REG_ASCII_FORBID, {7'd0, forbid});
    write_reg(REG_ILLEGAL_EN, {7'd0, ill_en});
    write_reg(REG_ILLEGAL_CHAR, ill_ch);
    cur_illegal = ill_ch;
    no_gaps     = (mode == PH_NO_GAPS);
    if (mode == PH_HOLD) hold_off = 1'b1;   // sender keeps pushing while results back up
    phase_words = 0;
    sent        = 0;
    while (phase_words < PHASE_WORDS) begin
      build_string();
      send_string();
      sent++;
      if (mode == PH_MID_DRAIN && sent == 6) wait_drained();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings, reset register values (ASCII escapes allowed, no illegal char).
    text_q = '{PCT_CHAR, 8'h32, 8'h66};        // "%2f": escape ends the string
    send_string();
    text_q = '{PCT_CHAR, 8'h34};               // cut off after one hex digit
    send_string();
    text_q = '{PCT_CHAR, 8'h67};               // non-hex digit on the last byte
    send_string();
    text_q = '{PCT_CHAR, 8'h30, 8'h30};        // escaped NUL
    send_string();
    text_q = '{8'hC3};                         // open sequence at end of string
    send_string();
    text_q = '{8'hC3, 8'h00};                  // raw NUL inside a sequence
    send_string();
    text_q = '{8'h00, 8'hFF};                  // NUL stops the UTF-8 check
    send_string();
    text_q = '{8'hFF};                         // never valid in UTF-8, not emitted
    send_string();
    text_q = '{PCT_CHAR, 8'h7A, 8'hFF};        // bad escape first, later bytes ignored
    send_string();
    text_q = '{8'hE0, 8'h9F};                  // overlong three-byte form
    send_string();
    text_q = '{PCT_CHAR, 8'h43, 8'h33, PCT_CHAR, 8'h61, 8'h39};  // "%C3%a9", mixed case
    send_string();

    // Random phases, one register setting each; extremes of illegal_char included.
    run_phase(1'b1, 1'b0, 8'h01, PH_PLAIN);
    run_phase(1'b0, 1'b1, 8'hFF, PH_HOLD);
    run_phase(1'b1, 1'b1, 8'hFF, PH_NO_GAPS);
    run_phase(1'b0, 1'b1, 8'h2F, PH_MID_DRAIN);
    run_phase(1'b1, 1'b1, 8'hC3, PH_PLAIN);
    run_phase(1'b0, 1'b1, 8'h00, PH_PLAIN);   // zero can never match
    run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              8'($urandom_range(1, 255)), PH_PLAIN);

    wait_drained();
    $display("Sent %0d input words in %0d strings under 8 register settings, with a long",
             n_words, n_strings);
    $display("result stall; %0d result words checked, status ok/bad/forbid/utf8 %0d/%0d/%0d/%0d",
             sb.checked, sb.by_status[STAT_OK], sb.by_status[STAT_BADESC],
             sb.by_status[STAT_FORBID], sb.by_status[STAT_UTF8]);
    if (sb.errors == 0) $display("PASS uri_percent_decoder");
    else $display("FAIL uri_percent_decoder");
    $finish;
  end
endmodule
